// File: rtl/core/clt_pkg.sv
// ----------------------------------------------------------------------------
// clt_pkg
// shared widths, codes and the queue item type of the circle/rectangle
// collision test
// ----------------------------------------------------------------------------
package clt_pkg;

  // field widths
  localparam int POS_W      = 24;
  localparam int SIZE_W     = 20;
  localparam int SCALE_W    = 16;
  localparam int FRAC_W     = 8;
  localparam int SHAPE_W    = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // derived datapath widths
  localparam int PROD_SZ_W = SIZE_W + SCALE_W;      // raw size times scale
  localparam int SSIZE_W   = PROD_SZ_W - FRAC_W;    // scaled size
  localparam int DIST_W    = POS_W + 1;             // centre distance magnitude
  localparam int OPND_W    = SSIZE_W + 1;           // squarer operand
  localparam int CMP_W     = OPND_W + 1;            // doubled distances, extents plus doubled radius
  localparam int SQ_W      = 2 * OPND_W;            // squarer result
  localparam int SUM_W     = SQ_W + 1;              // sum of two squares

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // shape type codes, the fourth code counts as none
  typedef enum logic [SHAPE_W-1:0] {
    SHAPE_NONE   = 2'd0,
    SHAPE_CIRCLE = 2'd1,
    SHAPE_RECT   = 2'd2
  } shape_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OWN_SHAPE  = 2'd0,
    CFG_OWN_WIDTH  = 2'd1,
    CFG_OWN_HEIGHT = 2'd2
  } cfg_reg_t;

  // pair class decided by the front
  typedef enum logic [2:0] {
    KIND_NONE = 3'd0,   // either type is none
    KIND_CC   = 3'd1,   // circle against circle
    KIND_CR   = 3'd2,   // own circle, other rectangle
    KIND_RC   = 3'd3,   // own rectangle, other circle
    KIND_RR   = 3'd4    // rectangle against rectangle
  } kind_t;

  // classified pair as it waits in the queue
  typedef struct packed {
    kind_t               kind;
    logic [DIST_W-1:0]   ax;
    logic [DIST_W-1:0]   ay;
    logic [SSIZE_W-1:0]  ow;
    logic [SSIZE_W-1:0]  oh;
    logic [SSIZE_W-1:0]  tw;
    logic [SSIZE_W-1:0]  th;
  } item_t;

endpackage

// File: rtl/core/clt_in_if.sv
// ----------------------------------------------------------------------------
// clt_in_if
// input channel: one shape pair per beat
// ----------------------------------------------------------------------------
interface clt_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [clt_pkg::POS_W-1:0]       own_x;
  logic signed [clt_pkg::POS_W-1:0]       own_y;
  logic        [clt_pkg::SCALE_W-1:0]     own_scale_x;
  logic        [clt_pkg::SCALE_W-1:0]     own_scale_y;
  logic        [clt_pkg::SHAPE_W-1:0]     other_shape;
  logic signed [clt_pkg::POS_W-1:0]       other_x;
  logic signed [clt_pkg::POS_W-1:0]       other_y;
  logic        [clt_pkg::SIZE_W-1:0]      other_width;
  logic        [clt_pkg::SIZE_W-1:0]      other_height;
  logic        [clt_pkg::SCALE_W-1:0]     other_scale_x;
  logic        [clt_pkg::SCALE_W-1:0]     other_scale_y;

  modport source (
    output valid, own_x, own_y, own_scale_x, own_scale_y, other_shape,
           other_x, other_y, other_width, other_height, other_scale_x,
           other_scale_y,
    input  ready
  );

  modport sink (
    input  valid, own_x, own_y, own_scale_x, own_scale_y, other_shape,
           other_x, other_y, other_width, other_height, other_scale_x,
           other_scale_y,
    output ready
  );
endinterface

// File: rtl/core/clt_out_if.sv
// ----------------------------------------------------------------------------
// clt_out_if
// result channel: hit and type error per beat
// ----------------------------------------------------------------------------
interface clt_out_if;
  logic valid;
  logic ready;
  logic hit;
  logic type_error;

  modport source (output valid, hit, type_error, input ready);
  modport sink   (input valid, hit, type_error, output ready);
endinterface

// File: rtl/core/clt_cfg_if.sv
// ----------------------------------------------------------------------------
// clt_cfg_if
// configuration write channel: register index and data per beat
// ----------------------------------------------------------------------------
interface clt_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [clt_pkg::CFG_IDX_W-1:0]       index;
  logic [clt_pkg::CFG_DATA_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/clt_front.sv
// ----------------------------------------------------------------------------
// clt_front
// holds the own shape registers, scales all sizes, takes the centre
// distances and classifies the pair for the back end
// ----------------------------------------------------------------------------
module clt_front (
  input  logic             clk,
  input  logic             rst_n,
  clt_in_if.sink           in_ch,
  clt_cfg_if.sink          cfg_ch,
  output clt_pkg::item_t   item,
  output logic             item_valid,
  input  logic             item_ready
);

  logic [clt_pkg::SHAPE_W-1:0]   own_shape_r;
  logic [clt_pkg::SIZE_W-1:0]    own_width_r;
  logic [clt_pkg::SIZE_W-1:0]    own_height_r;

  logic [clt_pkg::PROD_SZ_W-1:0] ow_p;
  logic [clt_pkg::PROD_SZ_W-1:0] oh_p;
  logic [clt_pkg::PROD_SZ_W-1:0] tw_p;
  logic [clt_pkg::PROD_SZ_W-1:0] th_p;
  logic [clt_pkg::DIST_W-1:0]    dx;
  logic [clt_pkg::DIST_W-1:0]    dy;
  logic                          own_ok;
  logic                          other_ok;
  clt_pkg::kind_t                kind;
  clt_pkg::item_t                item_nxt;
  clt_pkg::item_t                item_r;
  logic                          valid_r;
  logic                          accept;

  // configuration writes are always taken
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_shape_r  <= '0;
      own_width_r  <= '0;
      own_height_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (clt_pkg::cfg_reg_t'(cfg_ch.index))
        clt_pkg::CFG_OWN_SHAPE:  own_shape_r  <= cfg_ch.data[clt_pkg::SHAPE_W-1:0];
        clt_pkg::CFG_OWN_WIDTH:  own_width_r  <= cfg_ch.data[clt_pkg::SIZE_W-1:0];
        clt_pkg::CFG_OWN_HEIGHT: own_height_r <= cfg_ch.data[clt_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // size times scale, one multiplier each
  assign ow_p = clt_pkg::PROD_SZ_W'(own_width_r)        * clt_pkg::PROD_SZ_W'(in_ch.own_scale_x);
  assign oh_p = clt_pkg::PROD_SZ_W'(own_height_r)       * clt_pkg::PROD_SZ_W'(in_ch.own_scale_y);
  assign tw_p = clt_pkg::PROD_SZ_W'(in_ch.other_width)  * clt_pkg::PROD_SZ_W'(in_ch.other_scale_x);
  assign th_p = clt_pkg::PROD_SZ_W'(in_ch.other_height) * clt_pkg::PROD_SZ_W'(in_ch.other_scale_y);

  // signed centre differences, one bit wider than a position
  assign dx = {in_ch.other_x[clt_pkg::POS_W-1], in_ch.other_x}
            - {in_ch.own_x[clt_pkg::POS_W-1], in_ch.own_x};
  assign dy = {in_ch.other_y[clt_pkg::POS_W-1], in_ch.other_y}
            - {in_ch.own_y[clt_pkg::POS_W-1], in_ch.own_y};

  // pair classification
  assign own_ok   = (own_shape_r == clt_pkg::SHAPE_CIRCLE) ||
                    (own_shape_r == clt_pkg::SHAPE_RECT);
  assign other_ok = (in_ch.other_shape == clt_pkg::SHAPE_CIRCLE) ||
                    (in_ch.other_shape == clt_pkg::SHAPE_RECT);

  always_comb begin
    if (!own_ok || !other_ok) begin
      kind = clt_pkg::KIND_NONE;
    end else if (own_shape_r == clt_pkg::SHAPE_CIRCLE) begin
      kind = (in_ch.other_shape == clt_pkg::SHAPE_CIRCLE) ? clt_pkg::KIND_CC
                                                          : clt_pkg::KIND_CR;
    end else begin
      kind = (in_ch.other_shape == clt_pkg::SHAPE_CIRCLE) ? clt_pkg::KIND_RC
                                                          : clt_pkg::KIND_RR;
    end
  end

  // magnitudes and truncated scaled sizes
  always_comb begin
    item_nxt.kind = kind;
    item_nxt.ax   = dx[clt_pkg::DIST_W-1] ? (~dx + 1'b1) : dx;
    item_nxt.ay   = dy[clt_pkg::DIST_W-1] ? (~dy + 1'b1) : dy;
    item_nxt.ow   = ow_p[clt_pkg::PROD_SZ_W-1:clt_pkg::FRAC_W];
    item_nxt.oh   = oh_p[clt_pkg::PROD_SZ_W-1:clt_pkg::FRAC_W];
    item_nxt.tw   = tw_p[clt_pkg::PROD_SZ_W-1:clt_pkg::FRAC_W];
    item_nxt.th   = th_p[clt_pkg::PROD_SZ_W-1:clt_pkg::FRAC_W];
  end

  // one output stage toward the queue
  assign in_ch.ready = !valid_r || item_ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

  assign item       = item_r;
  assign item_valid = valid_r;

endmodule

// File: rtl/core/clt_fifo.sv
// ----------------------------------------------------------------------------
// clt_fifo
// short queue of classified pairs between front and back
// ----------------------------------------------------------------------------
module clt_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  clt_pkg::item_t   push_item,
  input  logic             push_valid,
  output logic             push_ready,
  output clt_pkg::item_t   pop_item,
  output logic             pop_valid,
  input  logic             pop_ready
);

  clt_pkg::item_t               mem_r [clt_pkg::QDEPTH];
  logic [clt_pkg::QPTR_W-1:0]   wr_ptr_r;
  logic [clt_pkg::QPTR_W-1:0]   rd_ptr_r;
  logic [clt_pkg::QCNT_W-1:0]   count_r;
  logic [clt_pkg::QCNT_W-1:0]   count_nxt;
  logic                         push;
  logic                         pop;

  assign push_ready = (count_r != clt_pkg::QCNT_W'(clt_pkg::QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem_r[rd_ptr_r];

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // pointers wrap at the queue depth
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == clt_pkg::QPTR_W'(clt_pkg::QDEPTH - 1)) ? '0
                                                                        : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == clt_pkg::QPTR_W'(clt_pkg::QDEPTH - 1)) ? '0
                                                                        : rd_ptr_r + 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: rtl/core/clt_back.sv
// ----------------------------------------------------------------------------
// clt_back
// three-stage test pipe: extent compares and squarer operands, three shared
// squarers, then sum of squares against the squared radius
// ----------------------------------------------------------------------------
module clt_back (
  input  logic             clk,
  input  logic             rst_n,
  input  clt_pkg::item_t   item,
  input  logic             item_valid,
  output logic             item_ready,
  clt_out_if.source        out_ch
);

  typedef struct packed {
    logic err;      // a type is none
    logic use_sq;   // the squared distance test applies
    logic direct;   // box or rectangle test already hit
  } flags_t;

  // stage 1 signals
  logic [clt_pkg::SSIZE_W-1:0] r;
  logic [clt_pkg::SSIZE_W-1:0] w;
  logic [clt_pkg::SSIZE_W-1:0] h;
  logic [clt_pkg::CMP_W-1:0]   x2;
  logic [clt_pkg::CMP_W-1:0]   y2;
  logic [clt_pkg::CMP_W-1:0]   r2;
  logic [clt_pkg::CMP_W-1:0]   we;
  logic [clt_pkg::CMP_W-1:0]   he;
  logic [clt_pkg::CMP_W-1:0]   ex;
  logic [clt_pkg::CMP_W-1:0]   ey;
  logic [clt_pkg::CMP_W-1:0]   sum_w;
  logic [clt_pkg::CMP_W-1:0]   sum_h;
  logic                        box_hit;
  logic                        rr_hit;
  flags_t                      flags1_nxt;
  logic [clt_pkg::OPND_W-1:0]  ma_nxt;
  logic [clt_pkg::OPND_W-1:0]  mb_nxt;
  logic [clt_pkg::OPND_W-1:0]  mc_nxt;

  // stage registers
  flags_t                      flags1_r;
  logic [clt_pkg::OPND_W-1:0]  ma_r;
  logic [clt_pkg::OPND_W-1:0]  mb_r;
  logic [clt_pkg::OPND_W-1:0]  mc_r;
  logic                        v1_r;
  flags_t                      flags2_r;
  logic [clt_pkg::SQ_W-1:0]    pa_r;
  logic [clt_pkg::SQ_W-1:0]    pb_r;
  logic [clt_pkg::SQ_W-1:0]    pc_r;
  logic                        v2_r;
  logic                        hit_r;
  logic                        err_r;
  logic                        v3_r;

  logic [clt_pkg::SUM_W-1:0]   d2;
  logic                        hit_nxt;
  logic                        rdy1;
  logic                        rdy2;
  logic                        rdy3;

  // ready chain through the stages
  assign rdy3       = !v3_r || out_ch.ready;
  assign rdy2       = !v2_r || rdy3;
  assign rdy1       = !v1_r || rdy2;
  assign item_ready = rdy1;

  // circle radius and rectangle extents for the mixed pair
  always_comb begin
    r = item.tw;
    w = item.ow;
    h = item.oh;
    if (item.kind == clt_pkg::KIND_CR) begin
      r = item.ow;
      w = item.tw;
      h = item.th;
    end
  end

  // doubled distances against full extents
  assign x2 = clt_pkg::CMP_W'({item.ax, 1'b0});
  assign y2 = clt_pkg::CMP_W'({item.ay, 1'b0});
  assign r2 = clt_pkg::CMP_W'({r, 1'b0});
  assign we = clt_pkg::CMP_W'(w);
  assign he = clt_pkg::CMP_W'(h);

  // two widened boxes
  assign box_hit = ((x2 < we) && (y2 < he + r2)) ||
                   ((x2 < we + r2) && (y2 < he));

  // full-extent sums for two rectangles, against doubled distances
  assign sum_w  = clt_pkg::CMP_W'(item.ow) + clt_pkg::CMP_W'(item.tw);
  assign sum_h  = clt_pkg::CMP_W'(item.oh) + clt_pkg::CMP_W'(item.th);
  assign rr_hit = (x2 < sum_w) && (y2 < sum_h);

  // offsets to the nearest corner, sign dropped for squaring
  assign ex = (x2 >= we) ? (x2 - we) : (we - x2);
  assign ey = (y2 >= he) ? (y2 - he) : (he - y2);

  // squarer operands and flags per pair class
  always_comb begin
    flags1_nxt = '0;
    ma_nxt     = ex[clt_pkg::OPND_W-1:0];
    mb_nxt     = ey[clt_pkg::OPND_W-1:0];
    mc_nxt     = r2[clt_pkg::OPND_W-1:0];
    unique case (item.kind)
      clt_pkg::KIND_CC: begin
        flags1_nxt.use_sq = 1'b1;
        ma_nxt = clt_pkg::OPND_W'(item.ax);
        mb_nxt = clt_pkg::OPND_W'(item.ay);
        mc_nxt = clt_pkg::OPND_W'(item.ow) + clt_pkg::OPND_W'(item.tw);
      end
      clt_pkg::KIND_CR, clt_pkg::KIND_RC: begin
        flags1_nxt.use_sq = 1'b1;
        flags1_nxt.direct = box_hit;
      end
      clt_pkg::KIND_RR: begin
        flags1_nxt.direct = rr_hit;
      end
      default: begin
        flags1_nxt.err = 1'b1;
      end
    endcase
  end

  // stage 1: operands
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && item_valid) begin
      flags1_r <= flags1_nxt;
      ma_r     <= ma_nxt;
      mb_r     <= mb_nxt;
      mc_r     <= mc_nxt;
    end
  end

  // stage 2: three squarers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      flags2_r <= flags1_r;
      pa_r     <= clt_pkg::SQ_W'(ma_r) * clt_pkg::SQ_W'(ma_r);
      pb_r     <= clt_pkg::SQ_W'(mb_r) * clt_pkg::SQ_W'(mb_r);
      pc_r     <= clt_pkg::SQ_W'(mc_r) * clt_pkg::SQ_W'(mc_r);
    end
  end

  // stage 3: squared distance against squared radius
  assign d2      = clt_pkg::SUM_W'(pa_r) + clt_pkg::SUM_W'(pb_r);
  assign hit_nxt = !flags2_r.err &&
                   (flags2_r.direct || (flags2_r.use_sq && (d2 < clt_pkg::SUM_W'(pc_r))));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      hit_r <= hit_nxt;
      err_r <= flags2_r.err;
    end
  end

  assign out_ch.valid      = v3_r;
  assign out_ch.hit        = hit_r;
  assign out_ch.type_error = err_r;

endmodule

// File: rtl/core/collision_test_2d_circle_rect_top.sv
// ----------------------------------------------------------------------------
// collision_test_2d_circle_rect_top
// narrow-phase overlap test of the configured own shape against one shape
// per input beat
// ----------------------------------------------------------------------------
// Takes one shape pair per clock while the result side keeps up, and
// returns one hit/type_error beat per pair, in order. The front stage
// (four size-by-scale multipliers and the centre differences) is loaded
// at the accepting edge; the pair then passes through the four-entry
// queue and three back stages (extent compares, three shared
// squarers, sum-and-compare). The
// squarers in the back stage set the per-pair work; all of it is
// pipelined, so the sustained rate is one pair per cycle while the result
// side takes a beat each cycle. Touching shapes do not hit. Write the own
// shape registers only while no pair is in flight; writes are always taken.
module collision_test_2d_circle_rect_top (
  input  logic       clk,
  input  logic       rst_n,
  clt_in_if.sink     in_ch,
  clt_out_if.source  out_ch,
  clt_cfg_if.sink    cfg_ch
);

  clt_pkg::item_t front_item;
  logic           front_valid;
  logic           front_ready;
  clt_pkg::item_t back_item;
  logic           back_valid;
  logic           back_ready;

  // classify and scale
  clt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .item       (front_item),
    .item_valid (front_valid),
    .item_ready (front_ready)
  );

  // decouple front and back
  clt_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_item  (front_item),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_item   (back_item),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready)
  );

  // overlap tests
  clt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (back_item),
    .item_valid (back_valid),
    .item_ready (back_ready),
    .out_ch     (out_ch)
  );

endmodule
